>>> src/i2cms_pkg.sv
// Shared types and constants of the I2C master bit sequencer.
// Used by i2cms_front, i2cms_back and i2c_master_bit_sequencer; no dependencies.
package i2cms_pkg;

	localparam int DATA_BITS = 8;

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;

	localparam logic [4:0] START_LAST_PHASE = 5'd3;
	localparam logic [4:0] STOP_LAST_PHASE  = 5'd2;
	localparam logic [4:0] READ_LAST_PHASE  = 5'd17;
	localparam logic [3:0] ACK_SLOT_BIT     = 4'd8;
	localparam logic [2:0] MSB_INDEX        = 3'd7;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       nack_bit;
		logic [8:0] sda_samples;
	} cmd_item_t;

	typedef struct packed {
		logic      valid;
		cmd_item_t item;
	} queue_head_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic sample_point;
		logic [7:0] rx_byte;
		logic ack_seen;
		logic last;
	} phase_t;

endpackage

>>> src/i2cms_front.sv
// Front end: accepts command requests, drops undefined codes, queues the rest.
// Depends on i2cms_pkg.
module i2cms_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  i2cms_pkg::cmd_item_t   in_item,
	output i2cms_pkg::queue_head_t head,
	input  logic                   pop
);
	import i2cms_pkg::*;

	cmd_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       accept;
	logic       push;
	logic       known;

	assign known    = (in_item.command == CMD_START) || (in_item.command == CMD_STOP) ||
	                  (in_item.command == CMD_WRITE) || (in_item.command == CMD_READ) ||
	                  (in_item.command == CMD_ACK);
	assign s_tready = (count_q != 2'd2);
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && known;

	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
	a_undefined_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !known) |=> (count_q == $past(count_q) - {1'b0, $past(pop)}))
		else $error("undefined command entered the queue");

endmodule

>>> src/i2cms_back.sv
// Back end: expands the queued command into bus phases, one per cycle while
// the receiver is not stalling, into an output register. Depends on i2cms_pkg.
module i2cms_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2cms_pkg::queue_head_t head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output i2cms_pkg::phase_t      phase
);
	import i2cms_pkg::*;

	logic [4:0] phase_q;
	logic [1:0] sub_q;
	logic [3:0] bit_q;
	logic       scl_q;
	logic       sda_q;
	logic       out_valid_q;
	phase_t     out_q;
	phase_t     nxt;
	logic       fire;
	logic       is_write;

	assign fire     = head.valid && (!out_valid_q || m_tready);
	assign pop      = fire && nxt.last;
	assign is_write = (head.item.command == CMD_WRITE);

	always_comb begin
		nxt = '{scl_level: scl_q, sda_level: sda_q, sample_point: 1'b0,
		        rx_byte: 8'd0, ack_seen: 1'b0, last: 1'b0};
		case (head.item.command)
			CMD_START: begin
				case (phase_q)
					5'd0:    nxt.sda_level = 1'b1;
					5'd1:    nxt.scl_level = 1'b1;
					5'd2:    nxt.sda_level = 1'b0;
					default: begin
						nxt.scl_level = 1'b0;
						nxt.last      = (phase_q == START_LAST_PHASE) || 1'b1;
					end
				endcase
			end
			CMD_STOP: begin
				case (phase_q)
					5'd0:    nxt.sda_level = 1'b0;
					5'd1:    nxt.scl_level = 1'b1;
					default: begin
						nxt.sda_level = 1'b1;
						nxt.last      = (phase_q == STOP_LAST_PHASE) || 1'b1;
					end
				endcase
			end
			CMD_WRITE, CMD_ACK: begin
				case (sub_q)
					2'd0: begin
						if (!is_write) begin
							nxt.sda_level = head.item.nack_bit;
						end else if (bit_q == ACK_SLOT_BIT) begin
							nxt.sda_level = 1'b1;
						end else begin
							nxt.sda_level = head.item.tx_byte[MSB_INDEX - bit_q[2:0]];
						end
					end
					2'd1: begin
						nxt.scl_level    = 1'b1;
						nxt.sample_point = is_write && (bit_q == ACK_SLOT_BIT);
					end
					default: begin
						nxt.scl_level = 1'b0;
						nxt.last      = !is_write || (bit_q == ACK_SLOT_BIT);
						nxt.ack_seen  = is_write && (bit_q == ACK_SLOT_BIT) &&
						                !head.item.sda_samples[0];
					end
				endcase
			end
			CMD_READ: begin
				if (phase_q == 5'd0) begin
					nxt.sda_level = 1'b1;
				end else if (phase_q == READ_LAST_PHASE) begin
					nxt.scl_level = 1'b0;
					nxt.last      = 1'b1;
					nxt.rx_byte   = head.item.sda_samples[8:1];
				end else begin
					nxt.scl_level    = ~phase_q[0];
					nxt.sample_point = ~phase_q[0];
				end
			end
			default: begin
				nxt.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 5'd0;
			sub_q       <= 2'd0;
			bit_q       <= 4'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				scl_q       <= nxt.scl_level;
				sda_q       <= nxt.sda_level;
				out_valid_q <= 1'b1;
				if (nxt.last) begin
					phase_q <= 5'd0;
					sub_q   <= 2'd0;
					bit_q   <= 4'd0;
				end else begin
					phase_q <= phase_q + 5'd1;
					sub_q   <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
					bit_q   <= bit_q + {3'd0, (sub_q == 2'd2)};
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign phase    = out_q;

	a_sample_high: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && phase.sample_point) |-> phase.scl_level)
		else $error("sample point while SCL low");
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (phase.ack_seen || (phase.rx_byte != 8'd0))) |-> phase.last)
		else $error("status reported before the last phase");
	a_last_scl_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && phase.last && !phase.scl_level) |-> !phase.sample_point)
		else $error("last phase with SCL low carries a sample");
	a_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pop) |-> (phase_q == 5'd0 && sub_q == 2'd0 && bit_q == 4'd0))
		else $error("phase counters not cleared after a command");

endmodule

>>> src/i2c_master_bit_sequencer.sv
// Top level of the byte-level I2C master bit sequencer.
// Depends on i2cms_pkg, i2cms_front and i2cms_back.
//
// Usage: each request on the s_ side is one command (start, stop, write byte,
// read byte, send acknowledge). The block answers on the m_ side with the
// command's run of bus phases, one request per phase, m_tlast on the final one.
// Runs are 4 (start), 3 (stop, ack), 18 (read) or 27 (write) phases long.
// Undefined command codes are accepted and produce nothing.
// An accepted command is written to the command queue, and its first phase
// then passes through the output register before it is offered. The back
// end's phase sequencer expands one phase per cycle while the receiver is
// ready; a two-entry command queue lets the next command be taken
// while the current one is still being expanded.
// Reset clears the queue and the output valid flag and returns both held line
// levels to the idle bus (SCL and SDA high).
// When the receiver stalls, the current phase holds on m_tdata and the
// sequencer waits; commands keep being accepted until the queue is full.
module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] command, [10:3] tx_byte, [11] nack_bit, [20:12] sda_samples
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] scl_level, [1] sda_level, [2] sample_point, [10:3] rx_byte, [11] ack_seen
	output logic [15:0] m_tdata,
	output logic        m_tlast
);
	import i2cms_pkg::*;

	cmd_item_t   in_item;
	queue_head_t head;
	phase_t      phase;
	logic        pop;

	assign in_item.command     = s_tdata[2:0];
	assign in_item.tx_byte     = s_tdata[10:3];
	assign in_item.nack_bit    = s_tdata[11];
	assign in_item.sda_samples = s_tdata[20:12];

	i2cms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	i2cms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.phase    (phase)
	);

	assign m_tdata = {4'd0, phase.ack_seen, phase.rx_byte, phase.sample_point,
	                  phase.sda_level, phase.scl_level};
	assign m_tlast = phase.last;

endmodule
